/* hw/rtl/pli_pkg.sv */
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared widths, codes, state and result enums, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pli_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned KEY_W     = 40;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned STS_W     = 2;

  // Product of a key difference and a value difference, and the divider.
  localparam int unsigned PROD_W    = KEY_W + VAL_W;
  localparam int unsigned HALF_W    = VAL_W / 2;
  localparam int unsigned PP_W      = KEY_W + HALF_W;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  // Item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    STS_INTERP = 2'd0,
    STS_BELOW  = 2'd1,
    STS_ABOVE  = 2'd2,
    STS_FEW    = 2'd3
  } pli_status_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_SCAN,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } pli_state_e;

  // Which result the datapath latches.
  typedef enum logic [1:0] {
    RES_FEW,
    RES_SPAN0,
    RES_CLAMP,
    RES_INTERP
  } pli_res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     mem_wr;
    logic     key_ld;
    logic     rd_en;
    logic     first_ld;
    logic     scan_step;
    logic     seg_ld;
    logic     mul_lo;
    logic     mul_hi;
    logic     div_step;
    logic     res_ld;
    pli_res_e res_kind;
    logic     out_ld;
  } pli_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic span_zero;
    logic out_full;
  } pli_sts_t;

endpackage

/* hw/rtl/pli_in_if.sv */
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one write or query item per transaction.
// ----------------------------------------------------------------------------
interface pli_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [pli_pkg::IDX_W-1:0]  point_index;
  logic [pli_pkg::KEY_W-1:0]  key;
  logic [pli_pkg::VAL_W-1:0]  point_value;

  modport source (output valid, func, point_index, key, point_value, input ready);
  modport sink   (input valid, func, point_index, key, point_value, output ready);
endinterface

/* hw/rtl/pli_out_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one query result per transaction.
// ----------------------------------------------------------------------------
interface pli_out_if;
  logic                       valid;
  logic                       ready;
  logic [pli_pkg::STS_W-1:0]  status;
  logic [pli_pkg::VAL_W-1:0]  estimate;

  modport source (output valid, status, estimate, input ready);
  modport sink   (input valid, status, estimate, output ready);
endinterface

/* hw/rtl/pli_ctrl.sv */
// ----------------------------------------------------------------------------
// Interpolator controller
// Holds the point count register and sequences each query through the
// breakpoint scan, the two-step multiply, the serial divide and the result.
// ----------------------------------------------------------------------------
module pli_ctrl #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned AW         = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pli_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_func_i,
  output logic                        in_ready_o,
  input  pli_pkg::pli_sts_t           sts_i,
  output pli_pkg::pli_cmd_t           cmd_o,
  output logic [AW-1:0]               rd_addr_o
);
  import pli_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  pli_state_e         state_q, state_d;
  logic [CNT_W-1:0]   point_count_q;
  logic [CW-1:0]      i_q, i_d, i_nxt, n_c;
  logic [DCNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic               in_accept;

  // Points in use, limited to the table depth.
  always_comb begin
    if (32'(point_count_q) > MAX_POINTS) begin
      n_c = CW'(MAX_POINTS);
    end else begin
      n_c = CW'(point_count_q);
    end
  end

  assign i_nxt     = i_q + 1'b1;
  assign in_accept = in_valid_i && in_ready_o;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
    end else if (cfg_we_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  // State, scan index and divide step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    div_cnt_d    = div_cnt_q;
    cmd_o        = '0;
    cmd_o.res_kind = RES_FEW;
    rd_addr_o    = AW'(i_nxt);
    in_ready_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr_o  = '0;
        i_d        = '0;
        if (in_accept) begin
          if (in_func_i == FUNC_WRITE) begin
            cmd_o.mem_wr = 1'b1;
          end else begin
            cmd_o.key_ld = 1'b1;
            if (n_c < CW'(2)) begin
              cmd_o.res_ld   = 1'b1;
              cmd_o.res_kind = RES_FEW;
              state_d        = ST_DONE;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = ST_LOAD0;
            end
          end
        end
      end
      ST_LOAD0: begin
        // First breakpoint is on the read port; fetch the second.
        cmd_o.first_ld = 1'b1;
        cmd_o.rd_en    = 1'b1;
        i_d            = i_nxt;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        // Entry i is on the read port, entry i-1 is held in the datapath.
        cmd_o.rd_en = 1'b1;
        if (sts_i.match) begin
          cmd_o.seg_ld = 1'b1;
          if (sts_i.span_zero) begin
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_kind = RES_SPAN0;
            state_d        = ST_DONE;
          end else begin
            state_d = ST_MUL_LO;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          if (i_nxt == n_c) begin
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_kind = RES_CLAMP;
            state_d        = ST_DONE;
          end else begin
            i_d = i_nxt;
          end
        end
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        div_cnt_d    = '0;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_kind = RES_INTERP;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // Wait until the output register can take the result.
        if (!sts_i.out_full) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The scan index always names a second or later breakpoint in use.
  a_scan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (i_q != '0 && i_q < n_c))
    else $error("scan index out of range");

  // A write transaction never leaves the idle state.
  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_func_i == FUNC_WRITE) |=> (state_q == ST_IDLE))
    else $error("write transaction started a query sequence");

  // The divider runs exactly its full number of steps.
  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_cnt_q == DCNT_W'(DIV_STEPS - 1)) |=> (state_q == ST_FIX))
    else $error("divide did not end after its last step");

endmodule

/* hw/rtl/pli_dpath.sv */
// ----------------------------------------------------------------------------
// Interpolator datapath
// Breakpoint memories, segment compare, shared 40x16 multiplier, restoring
// divider, result formation and the output register.
// ----------------------------------------------------------------------------
module pli_dpath #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned AW         = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pli_pkg::IDX_W-1:0]   in_point_index_i,
  input  logic [pli_pkg::KEY_W-1:0]   in_key_i,
  input  logic [pli_pkg::VAL_W-1:0]   in_point_value_i,
  input  pli_pkg::pli_cmd_t           cmd_i,
  input  logic [AW-1:0]               rd_addr_i,
  output pli_pkg::pli_sts_t           sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pli_pkg::STS_W-1:0]   out_status_o,
  output logic [pli_pkg::VAL_W-1:0]   out_estimate_o
);
  import pli_pkg::*;

  // Breakpoint memories.
  logic [KEY_W-1:0]  key_mem [MAX_POINTS];
  logic [VAL_W-1:0]  val_mem [MAX_POINTS];
  logic [KEY_W-1:0]  rd_key_q;
  logic [VAL_W-1:0]  rd_val_q;
  logic              wr_ok;

  // Query and scan registers.
  logic [KEY_W-1:0]  key_q, prev_key_q, first_key_q;
  logic [VAL_W-1:0]  prev_val_q, first_val_q;

  // Segment, multiply and divide registers.
  logic [KEY_W-1:0]  d_q, span_q, rem_q;
  logic [VAL_W-1:0]  v0_q, v1_q, mag_q, quo_q;
  logic              neg_q;
  logic [PROD_W-1:0] prod_q;
  logic [PP_W-1:0]   pp;
  logic [HALF_W-1:0] mul_half;
  logic [KEY_W:0]    trial, trial_sub;
  logic              trial_ge;
  logic [VAL_W-1:0]  q_adj;

  // Result and output registers.
  pli_status_e       res_status_q, out_status_q;
  logic [VAL_W-1:0]  res_est_q, out_est_q;
  logic              out_valid_q;

  // Writes beyond the table depth are dropped.
  assign wr_ok = (32'(in_point_index_i) < MAX_POINTS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && wr_ok) begin
      key_mem[AW'(in_point_index_i)] <= in_key_i;
      val_mem[AW'(in_point_index_i)] <= in_point_value_i;
    end
    if (cmd_i.rd_en) begin
      rd_key_q <= key_mem[rd_addr_i];
      rd_val_q <= val_mem[rd_addr_i];
    end
  end

  // Segment test against the held lower breakpoint and the read upper one.
  assign sts_o.match     = (key_q >= prev_key_q) && (key_q <= rd_key_q);
  assign sts_o.span_zero = (rd_key_q == prev_key_q);
  assign sts_o.out_full  = out_valid_q && !out_ready_i;

  // Shared multiplier: one 16-bit half of the value difference per cycle.
  assign mul_half = cmd_i.mul_hi ? mag_q[VAL_W-1:HALF_W] : mag_q[HALF_W-1:0];
  assign pp       = d_q * mul_half;

  // One restoring divide step per cycle, dividend bits taken from the top.
  assign trial     = {rem_q, prod_q[PROD_W-1]};
  assign trial_sub = trial - {1'b0, span_q};
  assign trial_ge  = (trial >= {1'b0, span_q});

  // Rounding toward minus infinity for a falling segment.
  assign q_adj = quo_q + VAL_W'(rem_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_ld) begin
      key_q <= in_key_i;
    end
    if (cmd_i.first_ld) begin
      first_key_q <= rd_key_q;
      first_val_q <= rd_val_q;
    end
    if (cmd_i.first_ld || cmd_i.scan_step) begin
      prev_key_q <= rd_key_q;
      prev_val_q <= rd_val_q;
    end
    if (cmd_i.seg_ld) begin
      d_q    <= key_q - prev_key_q;
      span_q <= rd_key_q - prev_key_q;
      v0_q   <= prev_val_q;
      v1_q   <= rd_val_q;
      neg_q  <= (rd_val_q < prev_val_q);
      mag_q  <= (rd_val_q < prev_val_q) ? (prev_val_q - rd_val_q) : (rd_val_q - prev_val_q);
    end
    if (cmd_i.mul_lo) begin
      prod_q <= PROD_W'(pp);
    end else if (cmd_i.mul_hi) begin
      prod_q <= prod_q + (PROD_W'(pp) << HALF_W);
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      prod_q <= prod_q << 1;
      rem_q  <= trial_ge ? trial_sub[KEY_W-1:0] : trial[KEY_W-1:0];
      quo_q  <= {quo_q[VAL_W-2:0], trial_ge};
    end
    if (cmd_i.res_ld) begin
      case (cmd_i.res_kind)
        RES_FEW: begin
          res_status_q <= STS_FEW;
          res_est_q    <= '0;
        end
        RES_SPAN0: begin
          res_status_q <= STS_INTERP;
          res_est_q    <= prev_val_q;
        end
        RES_CLAMP: begin
          if (key_q <= first_key_q) begin
            res_status_q <= STS_BELOW;
            res_est_q    <= first_val_q;
          end else begin
            res_status_q <= STS_ABOVE;
            res_est_q    <= rd_val_q;
          end
        end
        RES_INTERP: begin
          res_status_q <= STS_INTERP;
          res_est_q    <= neg_q ? (v0_q - q_adj) : (v0_q + quo_q);
        end
        default: begin
          res_status_q <= STS_FEW;
          res_est_q    <= '0;
        end
      endcase
    end
    if (cmd_i.out_ld) begin
      out_status_q <= res_status_q;
      out_est_q    <= res_est_q;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_estimate_o = out_est_q;

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> !sts_o.out_full)
    else $error("output register overwritten while stalled");

  // The divide remainder ends below the segment span.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_ld && cmd_i.res_kind == RES_INTERP) |-> (rem_q < span_q))
    else $error("divide remainder not below span");

  // An interpolated estimate lies between the two segment values.
  a_est_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_ld && cmd_i.res_kind == RES_INTERP) |=>
      (neg_q ? (res_est_q <= v0_q && res_est_q >= v1_q)
             : (res_est_q >= v0_q && res_est_q <= v1_q)))
    else $error("interpolated estimate outside segment");

endmodule

/* hw/rtl/piecewise_linear_interpolator.sv */
// Timing: a write transaction completes without leaving the idle state. A query scans the
// breakpoints up to its matching segment, then multiplies, divides and forms the result; a
// zero-span segment, a clamped key or a table with fewer than two points skips the arithmetic.
// The next item is taken in the cycle after the result is loaded.
// Throughput: one query at a time, set by the one-entry-per-cycle scan of the breakpoint
// memory read port and the 72-step restoring divider. Reset clears count, FSM, valid flag.
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table lookup with exact floor interpolation between neighbors,
// built as a controller and a datapath.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pli_pkg::CNT_W-1:0]  cfg_wdata_i,
  pli_in_if.sink                     item_i,
  pli_out_if.source                  result_o
);
  import pli_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);

  pli_cmd_t        cmd;
  pli_sts_t        sts;
  logic [AW-1:0]   rd_addr;
  logic            in_ready;

  // Sequencing of writes and queries.
  pli_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (item_i.valid),
    .in_func_i   (item_i.func),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  assign item_i.ready = in_ready;

  // Table storage and arithmetic.
  pli_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_point_index_i (item_i.point_index),
    .in_key_i         (item_i.key),
    .in_point_value_i (item_i.point_value),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .sts_o            (sts),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .out_status_o     (result_o.status),
    .out_estimate_o   (result_o.estimate)
  );

endmodule

/* dv/tb_piecewise_linear_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Loads breakpoint tables, sets the point count between phases and sends
// queries. Each result is checked against an in-bench interpolation of the
// same table or a result given with the query. A short directed list comes first, then randomized tables.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator;
  import pli_pkg::*;

  localparam int unsigned MAX_POINTS   = 256;
  localparam int unsigned ITEM_TARGET  = 1600;
  localparam int unsigned IDLE_GAP     = 4;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT  = 2500000;
  localparam int unsigned CALM_FIRST   = 700;
  localparam int unsigned CALM_LAST    = 1000;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 2500;

  typedef struct packed {
    pli_status_e      status;
    logic [VAL_W-1:0] estimate;
  } lookup_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    bit               typed;
    lookup_t          res;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  pli_in_if  item_if ();
  pli_out_if result_if ();

  // Shadow of the breakpoint table and the point count.
  logic [KEY_W-1:0] bp_key [MAX_POINTS];
  logic [VAL_W-1:0] bp_val [MAX_POINTS];
  logic [CNT_W-1:0] bp_count;

  lookup_t     pending_lookups [$];
  stim_row_t   directed_rows [$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycles;

  piecewise_linear_interpolator #(
    .MAX_POINTS (MAX_POINTS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Expected result of a query on the current table. A falling segment
  // rounds its quotient up, so that the subtraction gives the floor.
  function automatic lookup_t interpolate(input logic [KEY_W-1:0] qkey);
    int unsigned      n;
    int unsigned      i;
    bit               hit;
    logic [KEY_W-1:0] k0;
    logic [KEY_W-1:0] k1;
    logic [KEY_W-1:0] span;
    logic [VAL_W-1:0] v0;
    logic [VAL_W-1:0] v1;
    logic [PROD_W:0]  prod;
    logic [PROD_W:0]  quo;
    lookup_t          res;
    n = (bp_count > MAX_POINTS) ? MAX_POINTS : bp_count;
    res.status   = STS_FEW;
    res.estimate = '0;
    hit = 1'b0;
    if (n < 2) return res;
    for (i = 1; i < n && !hit; i++) begin
      k0 = bp_key[i-1];
      k1 = bp_key[i];
      if (qkey >= k0 && qkey <= k1) begin
        hit  = 1'b1;
        span = k1 - k0;
        v0   = bp_val[i-1];
        v1   = bp_val[i];
        res.status   = STS_INTERP;
        res.estimate = v0;
        if (span != 0) begin
          if (v1 >= v0) begin
            prod = (qkey - k0) * (v1 - v0);
            quo  = prod / span;
            res.estimate = v0 + quo[VAL_W-1:0];
          end else begin
            prod = (qkey - k0) * (v0 - v1);
            quo  = (prod + span - 1) / span;
            res.estimate = v0 - quo[VAL_W-1:0];
          end
        end
      end
    end
    if (!hit) begin
      if (qkey <= bp_key[0]) begin
        res.status   = STS_BELOW;
        res.estimate = bp_val[0];
      end else begin
        res.status   = STS_ABOVE;
        res.estimate = bp_val[n-1];
      end
    end
    return res;
  endfunction

  // Random key: full range, a tiny range full of repeats, or a random scale.
  function automatic logic [KEY_W-1:0] rand_key(input int unsigned mode);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case (mode)
      0:       return r[KEY_W-1:0];
      1:       return KEY_W'(r[5:0]);
      default: return r[KEY_W-1:0] >> $urandom_range(KEY_W - 1);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    return $urandom;
  endfunction

  // Query keys mostly land inside a segment or on its ends.
  function automatic logic [KEY_W-1:0] pick_query_key(input int unsigned n);
    int unsigned      sel;
    int unsigned      s;
    logic [KEY_W:0]   width;
    logic [63:0]      r;
    logic [KEY_W-1:0] k0;
    logic [KEY_W-1:0] k1;
    sel = $urandom_range(99);
    r   = {$urandom, $urandom};
    if (n < 2 || sel >= 80) return rand_key($urandom_range(2));
    s  = $urandom_range(n - 1, 1);
    k0 = bp_key[s-1];
    k1 = bp_key[s];
    if (sel < 45) begin
      if (k1 < k0) return k0;
      width = {1'b0, k1} - {1'b0, k0} + 1'b1;
      return k0 + KEY_W'(r % width);
    end
    if (sel < 60) return k1;
    // Neighbors of the ends; these wrap at the extremes of the key range.
    if (sel < 70) return r[0] ? k0 - 1'b1 : k1 + 1'b1;
    return r[0] ? '0 : '1;
  endfunction

  task automatic wait_drained(input int unsigned extra);
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // The count register is only written with the block idle.
  task automatic set_point_count(input logic [CNT_W-1:0] cnt);
    item_if.valid <= 1'b0;
    wait_drained(IDLE_GAP);
    cfg_we    <= 1'b1;
    cfg_wdata <= cnt;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    bp_count  = cnt;
  endtask

  // One input transaction, with a random gap in front of it outside the
  // calm window. The table shadow is updated when the transaction completes.
  task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                           input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val,
                           input bit typed, input lookup_t typed_res);
    int unsigned gap;
    gap = 0;
    if (items_sent < CALM_FIRST || items_sent >= CALM_LAST)
      while ($urandom_range(99) < 11) gap++;
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.func        <= func;
    item_if.point_index <= idx;
    item_if.key         <= key;
    item_if.point_value <= val;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    items_sent++;
    if (func == FUNC_WRITE) begin
      bp_key[idx] = key;
      bp_val[idx] = val;
    end else begin
      pending_lookups.push_back(typed ? typed_res : interpolate(key));
    end
  endtask

  task automatic row_cfg(input logic [CNT_W-1:0] cnt);
    stim_row_t row;
    row = '{ROW_CFG, FUNC_WRITE, '0, '0, VAL_W'(cnt), 1'b0, '0};
    directed_rows.push_back(row);
  endtask

  task automatic row_write(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val);
    stim_row_t row;
    row = '{ROW_ITEM, FUNC_WRITE, idx, key, val, 1'b0, '0};
    directed_rows.push_back(row);
  endtask

  task automatic row_query(input logic [KEY_W-1:0] key, input bit typed,
                           input pli_status_e sts, input logic [VAL_W-1:0] est);
    stim_row_t row;
    lookup_t   res;
    res.status   = sts;
    res.estimate = est;
    row = '{ROW_ITEM, FUNC_QUERY, 8'hA5, key, 32'h5A5A_A5A5, typed, res};
    directed_rows.push_back(row);
  endtask

  // One random phase: set a count, load a table prefix, then mostly queries.
  // The first phase fills every slot, so any later count reads written data.
  task automatic run_table_phase(input int unsigned pnum);
    int unsigned      cnt;
    int unsigned      n;
    int unsigned      ld;
    int unsigned      nq;
    int unsigned      sel;
    int unsigned      mode;
    int unsigned      i;
    bit               sorted;
    logic [KEY_W-1:0] step_key;
    logic [KEY_W-1:0] k;
    if (pnum == 0) begin
      cnt = 511;
    end else if (pnum == 1) begin
      cnt = MAX_POINTS;
    end else begin
      sel = $urandom_range(99);
      if (sel < 6)       cnt = $urandom_range(1);
      else if (sel < 10) cnt = $urandom_range(511, 17);
      else               cnt = $urandom_range(16, 2);
    end
    n = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
    if (pnum == 0)      ld = MAX_POINTS;
    else if (cnt <= 16) ld = cnt;
    else                ld = $urandom_range(8);
    set_point_count(CNT_W'(cnt));

    // Sorted tables grow by random steps sized to stay in the key range.
    mode   = $urandom_range(2);
    sorted = ($urandom_range(99) < 85);
    k      = rand_key(mode) / (ld + 1);
    for (i = 0; i < ld; i++) begin
      if (sorted) begin
        step_key = rand_key(mode) / (ld + 1);
        send_item(FUNC_WRITE, IDX_W'(i), k, rand_value(), 1'b0, '0);
        k = k + step_key;
      end else begin
        send_item(FUNC_WRITE, IDX_W'(i), rand_key(mode), rand_value(), 1'b0, '0);
      end
    end

    nq = (n > 32) ? $urandom_range(10, 4) : $urandom_range(40, 10);
    for (i = 0; i < nq; i++) begin
      if ($urandom_range(99) < 8)
        send_item(FUNC_WRITE, IDX_W'($urandom_range(255)), rand_key($urandom_range(2)),
                  rand_value(), 1'b0, '0);
      else
        send_item(FUNC_QUERY, IDX_W'($urandom_range(255)), pick_query_key(n), $urandom,
                  1'b0, '0);
    end
  endtask

  // Result side: random stalls, one long hold-off, and the checks.
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    lookup_t     want;
    hold_left = 0;
    held      = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) begin
        if (pending_lookups.size() == 0) begin
          $error("unexpected result: status %0d, estimate %h",
                 result_if.status, result_if.estimate);
          mismatches++;
        end else begin
          want = pending_lookups.pop_front();
          if (result_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result_if.status);
            mismatches++;
          end
          if (result_if.estimate !== want.estimate) begin
            $error("estimate: expected %h, actual %h", want.estimate, result_if.estimate);
            mismatches++;
          end
        end
        results_seen++;
      end
      if (!held && results_seen == HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= ($urandom_range(99) >= 11);
      end
    end
  end

  // Reset, directed list, random phases, drain and verdict.
  initial begin : stimulus
    int unsigned pnum;
    stim_row_t   row;
    items_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    cycles       = 0;
    bp_count     = '0;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    item_if.valid       <= 1'b0;
    item_if.func        <= FUNC_WRITE;
    item_if.point_index <= '0;
    item_if.key         <= '0;
    item_if.point_value <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty and one-point tables give no estimate.
    row_query(40'd0, 1'b1, STS_FEW, 32'd0);
    row_cfg(9'd0);
    row_write(8'd0, 40'd50, 32'd1000);
    row_write(8'd1, 40'd50, 32'd2000);
    row_write(8'd2, 40'd1000, 32'hFFFF_FFFF);
    row_write(8'd3, 40'hFF_FFFF_FFFF, 32'd0);
    row_cfg(9'd1);
    row_query(40'hFF_FFFF_FFFF, 1'b1, STS_FEW, 32'd0);
    // Below the table, a zero-width first segment, rising and falling ends.
    row_cfg(9'd4);
    row_query(40'd0, 1'b1, STS_BELOW, 32'd1000);
    row_query(40'd50, 1'b1, STS_INTERP, 32'd1000);
    row_query(40'd51, 1'b0, STS_INTERP, '0);
    row_query(40'd1000, 1'b1, STS_INTERP, 32'hFFFF_FFFF);
    row_query(40'd1001, 1'b0, STS_INTERP, '0);
    row_query(40'h80_0000_0000, 1'b0, STS_INTERP, '0);
    row_query(40'hFF_FFFF_FFFF, 1'b1, STS_INTERP, 32'd0);
    // Above the table takes the last value in use.
    row_cfg(9'd3);
    row_query(40'd1001, 1'b1, STS_ABOVE, 32'hFFFF_FFFF);
    row_write(8'd255, 40'h55_AAAA_5555, 32'hA5A5_5A5A);
    row_cfg(9'd2);
    row_query(40'd49, 1'b1, STS_BELOW, 32'd1000);
    row_query(40'd51, 1'b1, STS_ABOVE, 32'd2000);
    // Unsorted table: a key in a gap past the first key is clamped above.
    row_write(8'd1, 40'd60, 32'd7);
    row_write(8'd2, 40'd20, 32'd8);
    row_write(8'd3, 40'd30, 32'd9);
    row_cfg(9'd4);
    row_query(40'd65, 1'b1, STS_ABOVE, 32'd9);
    row_query(40'd25, 1'b0, STS_INTERP, '0);
    row_query(40'd55, 1'b0, STS_INTERP, '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG)
        set_point_count(row.val[CNT_W-1:0]);
      else
        send_item(row.func, row.idx, row.key, row.val, row.typed, row.res);
    end

    pnum = 0;
    while (items_sent < ITEM_TARGET) begin
      run_table_phase(pnum);
      pnum++;
    end

    item_if.valid <= 1'b0;
    wait_drained(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
